@@ rtl/efe_pkg.sv @@
// shared constants, types and codes of the encrypted frame encoder
package efe_pkg;

    localparam int MAX_PAYLOAD = 96;

    localparam logic [7:0] SOF_A = 8'hAA;
    localparam logic [7:0] SOF_B = 8'h55;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [31:0] TEA_DELTA  = 32'h9E3779B9;
    localparam int          TEA_ROUNDS = 32;
    localparam int          TEA_STEPS  = 2 * TEA_ROUNDS;
    localparam int          STEP_W     = $clog2(TEA_STEPS);

    localparam logic [7:0] FT_CYCLIC = 8'h01;
    localparam logic [7:0] FT_WARN   = 8'h02;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd4;

    localparam logic        ENCRYPT_RESET = 1'b1;
    localparam logic [31:0] KEY0_RESET    = 32'h12345678;
    localparam logic [31:0] KEY1_RESET    = 32'h9ABCDEF0;
    localparam logic [31:0] KEY2_RESET    = 32'h0F1E2D3C;
    localparam logic [31:0] KEY3_RESET    = 32'h44556677;

    typedef logic [3:0][31:0] key_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } emit_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tea_stat_t;

endpackage

@@ rtl/efe_crc.sv @@
// crc-16/modbus accumulator, one byte per feed
module efe_crc (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        clear,
    input  logic        feed,
    input  logic [7:0]  data,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] upd;

    always_comb begin
        upd = crc_reg ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            upd = upd[0] ? ((upd >> 1) ^ efe_pkg::CRC_POLY) : (upd >> 1);
        end
    end

    always_comb begin
        crc_next = crc_reg;
        if (clear) begin
            crc_next = efe_pkg::CRC_INIT;
        end else if (feed) begin
            crc_next = upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= efe_pkg::CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

@@ rtl/efe_tea.sv @@
// iterative tea cipher, one half round per cycle through a shared round unit
module efe_tea (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       v_in,
    input  efe_pkg::key_t     key,
    output logic [63:0]       result,
    output efe_pkg::tea_stat_t stat
);

    logic [31:0] v0_reg, v0_next;
    logic [31:0] v1_reg, v1_next;
    logic [31:0] sum_reg, sum_next;
    logic [efe_pkg::STEP_W-1:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    logic        odd;
    logic [31:0] x, acc, ka, kb, f, upd;

    // shared round unit: even steps update v0, odd steps update v1
    always_comb begin
        odd = step_reg[0];
        x   = odd ? v0_reg : v1_reg;
        acc = odd ? v1_reg : v0_reg;
        ka  = odd ? key[2] : key[0];
        kb  = odd ? key[3] : key[1];
        f   = ((x << 4) + ka) ^ (x + sum_reg) ^ ((x >> 5) + kb);
        upd = acc + f;
    end

    always_comb begin
        v0_next   = v0_reg;
        v1_next   = v1_reg;
        sum_next  = sum_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            v0_next   = v_in[31:0];
            v1_next   = v_in[63:32];
            sum_next  = efe_pkg::TEA_DELTA;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (odd) begin
                v1_next  = upd;
                sum_next = sum_reg + efe_pkg::TEA_DELTA;
            end else begin
                v0_next = upd;
            end
            step_next = step_reg + efe_pkg::STEP_W'(1);
            if (step_reg == efe_pkg::STEP_W'(efe_pkg::TEA_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        v0_reg  <= v0_next;
        v1_reg  <= v1_next;
        sum_reg <= sum_next;
    end

    assign result    = {v1_reg, v0_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ rtl/efe_obuf.sv @@
// output register of the byte stream
module efe_obuf (
    input  logic          aclk,
    input  logic          aresetn,
    input  efe_pkg::emit_t emit,
    output logic          ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;

    assign ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (ready) begin
            valid_next = emit.valid;
            data_next  = emit.data;
            last_next  = emit.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/encrypted_frame_encoder.sv @@
// top level of the encrypted frame encoder: sequencer, registers and datapath
//
// usage: payload items enter on the s_ channel, one byte each, tagged with the
// frame type (s_tuser) and the payload length (s_tdata[15:8]); the first item
// of a frame fixes type and length. the m_ channel carries the serialized
// frame AA 55 len type payload crc_lo crc_hi, m_tlast on crc_hi. the cfg
// channel writes encrypt_enable (index 0) and key words 0..3 (index 1..4);
// the user must write them only while the block is idle, and the block
// itself does not enforce this; cfg_ready is always high.
// input handshake: one item at a time; s_tready is high only while idle.
// a frame's first item first sends the header bytes. each item then passes
// the body state and goes on to plain output of its byte; or, if it only
// fills the encrypted block buffer, straight to check; or, if it completes
// a block, to the wait on the tea unit, which runs one half round per cycle
// and flags its result when done, and then to the eight cipher bytes. check
// follows, and the crc bytes after a frame's last kept item.
// reset restores the register defaults and returns to idle between frames.
// a stalled receiver holds the output register and the sequencer waits on
// every byte it emits, so nothing is lost.
module encrypted_frame_encoder #(
    parameter int MAX_PAYLOAD = efe_pkg::MAX_PAYLOAD
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // data_byte, payload_length
    input  logic [7:0]                    s_tuser,   // frame_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [efe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int FL_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HDR   = 3'd1;
    localparam logic [2:0] ST_BODY  = 3'd2;
    localparam logic [2:0] ST_PLAIN = 3'd3;
    localparam logic [2:0] ST_TEA   = 3'd4;
    localparam logic [2:0] ST_CIPH  = 3'd5;
    localparam logic [2:0] ST_CHK   = 3'd6;
    localparam logic [2:0] ST_CRC   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] byte_count_reg, byte_count_next;

    logic [FL_W-1:0] fl_reg, fl_next;
    logic [7:0]      raw_reg, raw_next;
    logic            enc_frame_reg, enc_frame_next;
    logic [7:0]      hl_reg, hl_next;
    logic [7:0]      type_reg, type_next;
    logic [7:0]      data_reg, data_next;
    logic [7:0]      pos_reg, pos_next;
    logic [63:0]     buf_reg, buf_next;

    logic          enc_en_reg, enc_en_next;
    efe_pkg::key_t key_reg, key_next;

    logic            acc;
    logic            first;
    logic [7:0]      pl_in, sat, pos_now, raw_now;
    logic [8:0]      cnt_inc, hl9;
    logic [FL_W-1:0] fl_new;
    logic            enc_new;
    logic            in_len, seal, is_last;
    logic [63:0]     buf_wr;

    efe_pkg::emit_t     emit;
    logic               crc_feed, crc_clear;
    logic [15:0]        crc;
    logic               ob_ready;
    logic               tea_start;
    logic [63:0]        tea_result;
    efe_pkg::tea_stat_t tea_stat;

    efe_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (crc_clear),
        .feed    (crc_feed),
        .data    (emit.data),
        .crc     (crc)
    );

    efe_tea u_tea (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tea_start),
        .v_in    (buf_wr),
        .key     (key_reg),
        .result  (tea_result),
        .stat    (tea_stat)
    );

    efe_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .ready    (ob_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        enc_en_next = enc_en_reg;
        key_next    = key_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                efe_pkg::CFG_ENCRYPT: enc_en_next = cfg_data[0];
                efe_pkg::CFG_KEY0:    key_next[0] = cfg_data;
                efe_pkg::CFG_KEY1:    key_next[1] = cfg_data;
                efe_pkg::CFG_KEY2:    key_next[2] = cfg_data;
                efe_pkg::CFG_KEY3:    key_next[3] = cfg_data;
                default:              enc_en_next = enc_en_reg;
            endcase
        end
    end

    // frame setup from the accepted item
    always_comb begin
        acc     = s_tvalid && s_tready;
        first   = !in_frame_reg;
        pl_in   = s_tdata[15:8];
        sat     = (pl_in > MAX_B) ? MAX_B : pl_in;
        fl_new  = FL_W'(sat);
        enc_new = enc_en_reg && (s_tuser == efe_pkg::FT_CYCLIC ||
                                 s_tuser == efe_pkg::FT_WARN);
        hl9     = enc_new ? ((9'(sat) + 9'd7) & ~9'd7) : 9'(sat);
        pos_now = first ? 8'd0 : byte_count_reg;
        raw_now = first ? pl_in : raw_reg;
        cnt_inc = 9'(pos_now) + 9'd1;
    end

    always_comb begin
        in_len  = 9'(pos_reg) < 9'(fl_reg);
        seal    = (pos_reg[2:0] == 3'd7) || (9'(pos_reg) + 9'd1 == 9'(fl_reg));
        is_last = (9'(pos_reg) + 9'd1 == 9'(fl_reg)) ||
                  (fl_reg == '0 && pos_reg == 8'd0);
        buf_wr  = buf_reg;
        buf_wr[{pos_reg[2:0], 3'b000} +: 8] = data_reg;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        fl_next         = fl_reg;
        raw_next        = raw_reg;
        enc_frame_next  = enc_frame_reg;
        hl_next         = hl_reg;
        type_next       = type_reg;
        data_next       = data_reg;
        pos_next        = pos_reg;
        buf_next        = buf_reg;
        emit            = '0;
        crc_feed        = 1'b0;
        crc_clear       = 1'b0;
        tea_start       = 1'b0;
        s_tready        = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (first) begin
                        fl_next        = fl_new;
                        raw_next       = pl_in;
                        enc_frame_next = enc_new;
                        hl_next        = hl9[7:0];
                        type_next      = s_tuser;
                        buf_next       = '0;
                        crc_clear      = 1'b1;
                    end
                    data_next       = s_tdata[7:0];
                    pos_next        = pos_now;
                    byte_count_next = cnt_inc[7:0];
                    in_frame_next   = !(cnt_inc >= 9'(raw_now));
                    idx_next        = '0;
                    state_next      = first ? ST_HDR : ST_BODY;
                end
            end
            ST_HDR: begin
                if (ob_ready) begin
                    emit.valid = 1'b1;
                    unique case (idx_reg[1:0])
                        2'd0:    emit.data = efe_pkg::SOF_A;
                        2'd1:    emit.data = efe_pkg::SOF_B;
                        2'd2:    emit.data = hl_reg;
                        default: emit.data = type_reg;
                    endcase
                    crc_feed = idx_reg[1];
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg[1:0] == 2'd3) begin
                        state_next = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                if (in_len && enc_frame_reg) begin
                    if (seal) begin
                        tea_start  = 1'b1;
                        buf_next   = '0;
                        state_next = ST_TEA;
                    end else begin
                        buf_next   = buf_wr;
                        state_next = ST_CHK;
                    end
                end else if (in_len) begin
                    state_next = ST_PLAIN;
                end else begin
                    state_next = ST_CHK;
                end
            end
            ST_PLAIN: begin
                if (ob_ready) begin
                    emit.valid = 1'b1;
                    emit.data  = data_reg;
                    crc_feed   = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_TEA: begin
                if (tea_stat.done) begin
                    idx_next   = '0;
                    state_next = ST_CIPH;
                end
            end
            ST_CIPH: begin
                if (ob_ready) begin
                    emit.valid = 1'b1;
                    emit.data  = tea_result[{idx_reg, 3'b000} +: 8];
                    crc_feed   = 1'b1;
                    idx_next   = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                idx_next   = '0;
                state_next = is_last ? ST_CRC : ST_IDLE;
            end
            ST_CRC: begin
                if (ob_ready) begin
                    emit.valid = 1'b1;
                    emit.data  = idx_reg[0] ? crc[15:8] : crc[7:0];
                    emit.last  = idx_reg[0];
                    idx_next   = idx_reg + 3'd1;
                    if (idx_reg[0]) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            in_frame_reg   <= 1'b0;
            byte_count_reg <= '0;
            fl_reg         <= '0;
            raw_reg        <= '0;
            enc_frame_reg  <= 1'b0;
            enc_en_reg     <= efe_pkg::ENCRYPT_RESET;
            key_reg        <= {efe_pkg::KEY3_RESET, efe_pkg::KEY2_RESET,
                               efe_pkg::KEY1_RESET, efe_pkg::KEY0_RESET};
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            in_frame_reg   <= in_frame_next;
            byte_count_reg <= byte_count_next;
            fl_reg         <= fl_next;
            raw_reg        <= raw_next;
            enc_frame_reg  <= enc_frame_next;
            enc_en_reg     <= enc_en_next;
            key_reg        <= key_next;
        end
    end

    always_ff @(posedge aclk) begin
        hl_reg   <= hl_next;
        type_reg <= type_next;
        data_reg <= data_next;
        pos_reg  <= pos_next;
        buf_reg  <= buf_next;
    end

    // no byte is pushed while the output register is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> ob_ready)
        else $error("byte emitted while output register full");

    // one item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // the cipher only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        tea_stat.done |-> state_reg == ST_TEA)
        else $error("tea result outside of cipher wait");

    // waiting on the cipher implies it is running or has finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TEA && !$past(tea_start)) |-> (tea_stat.busy || tea_stat.done))
        else $error("sequencer waits on an idle tea unit");

endmodule

@@ bench/tb.sv @@
// self-checking bench for encrypted_frame_encoder: scoreboard with tea/crc prediction and stimulus
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
} frame_byte_t;

class tea_frame_predictor;
    bit          encrypt_enable;
    bit [31:0]   key_word[4];
    bit          in_frame;
    bit [7:0]    byte_count;
    int          frame_length;
    int          raw_length;
    bit          encrypt_frame;
    bit [7:0]    block_buffer[8];
    bit [15:0]   crc_register;
    frame_byte_t expected_frame_bytes[$];
    int          errors;
    int          items_taken;
    int          frames_closed;
    int          blocks_sealed;
    int          bytes_checked;

    function new();
        encrypt_enable = efe_pkg::ENCRYPT_RESET;
        key_word[0]    = efe_pkg::KEY0_RESET;
        key_word[1]    = efe_pkg::KEY1_RESET;
        key_word[2]    = efe_pkg::KEY2_RESET;
        key_word[3]    = efe_pkg::KEY3_RESET;
        in_frame       = 1'b0;
        byte_count     = '0;
        frame_length   = 0;
        raw_length     = 0;
        encrypt_frame  = 1'b0;
        crc_register   = efe_pkg::CRC_INIT;
        foreach (block_buffer[i]) block_buffer[i] = '0;
    endfunction

    function void write_register(logic [efe_pkg::CFG_IDX_W-1:0] index, logic [31:0] value);
        unique case (index)
            efe_pkg::CFG_ENCRYPT: encrypt_enable = value[0];
            efe_pkg::CFG_KEY0:    key_word[0] = value;
            efe_pkg::CFG_KEY1:    key_word[1] = value;
            efe_pkg::CFG_KEY2:    key_word[2] = value;
            efe_pkg::CFG_KEY3:    key_word[3] = value;
            default: ;
        endcase
    endfunction

    function bit [15:0] crc16_modbus_step(bit [15:0] crc, bit [7:0] value);
        bit [15:0] c;
        c = crc ^ {8'h00, value};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ efe_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function void emit(bit [7:0] value, bit frame_end, bit in_crc);
        frame_byte_t fb;
        fb.out_byte  = value;
        fb.frame_end = frame_end;
        expected_frame_bytes.push_back(fb);
        if (in_crc)
            crc_register = crc16_modbus_step(crc_register, value);
    endfunction

    function void seal_block();
        bit [31:0] v0;
        bit [31:0] v1;
        bit [31:0] sum;
        v0  = {block_buffer[3], block_buffer[2], block_buffer[1], block_buffer[0]};
        v1  = {block_buffer[7], block_buffer[6], block_buffer[5], block_buffer[4]};
        sum = '0;
        for (int r = 0; r < efe_pkg::TEA_ROUNDS; r++) begin
            sum = sum + efe_pkg::TEA_DELTA;
            v0 = v0 + (((v1 << 4) + key_word[0]) ^ (v1 + sum) ^ ((v1 >> 5) + key_word[1]));
            v1 = v1 + (((v0 << 4) + key_word[2]) ^ (v0 + sum) ^ ((v0 >> 5) + key_word[3]));
        end
        for (int i = 0; i < 4; i++) emit(v0[8*i +: 8], 1'b0, 1'b1);
        for (int i = 0; i < 4; i++) emit(v1[8*i +: 8], 1'b0, 1'b1);
        foreach (block_buffer[i]) block_buffer[i] = '0;
        blocks_sealed++;
    endfunction

    function void take_payload_item(bit [7:0] data_byte, bit [7:0] frame_type,
                                    bit [7:0] payload_length);
        int pos;
        int header_length;
        items_taken++;
        if (!in_frame) begin
            raw_length    = payload_length;
            frame_length  = (payload_length > efe_pkg::MAX_PAYLOAD) ?
                            efe_pkg::MAX_PAYLOAD : payload_length;
            encrypt_frame = encrypt_enable && (frame_type == efe_pkg::FT_CYCLIC ||
                                               frame_type == efe_pkg::FT_WARN);
            header_length = encrypt_frame ? ((frame_length + 7) / 8) * 8 : frame_length;
            crc_register  = efe_pkg::CRC_INIT;
            byte_count    = '0;
            foreach (block_buffer[i]) block_buffer[i] = '0;
            in_frame      = 1'b1;
            emit(efe_pkg::SOF_A, 1'b0, 1'b0);
            emit(efe_pkg::SOF_B, 1'b0, 1'b0);
            emit(8'(header_length), 1'b0, 1'b1);
            emit(frame_type, 1'b0, 1'b1);
        end
        pos        = byte_count;
        byte_count = byte_count + 8'd1;
        if (pos < frame_length) begin
            if (encrypt_frame) begin
                block_buffer[pos % 8] = data_byte;
                if ((pos % 8) == 7 || pos + 1 == frame_length)
                    seal_block();
            end else begin
                emit(data_byte, 1'b0, 1'b1);
            end
        end
        if (pos + 1 == frame_length || (frame_length == 0 && pos == 0)) begin
            emit(crc_register[7:0], 1'b0, 1'b0);
            emit(crc_register[15:8], 1'b1, 1'b0);
            frames_closed++;
        end
        if (pos + 1 >= raw_length)
            in_frame = 1'b0;
    endfunction

    function void check_frame_byte(logic [7:0] out_byte, logic frame_end);
        frame_byte_t want;
        bytes_checked++;
        if (expected_frame_bytes.size() == 0) begin
            $error("unexpected output item: out_byte %02h frame_end %0b", out_byte, frame_end);
            errors++;
            return;
        end
        want = expected_frame_bytes.pop_front();
        if (out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, out_byte);
            errors++;
        end
        if (frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b", want.frame_end, frame_end);
            errors++;
        end
    endfunction
endclass

module tb;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;   // data_byte, payload_length
    logic [7:0]                    s_tuser;   // frame_type
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;   // out_byte
    logic                          m_tlast;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [efe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_data;

    logic calm;
    logic hold_toggle;
    int   sent_items;

    tea_frame_predictor frames;

    encrypted_frame_encoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb failed");
        $finish;
    end

    // receiver: random backpressure plus one long hold-off when hold_toggle flips
    initial begin
        int  hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_toggle !== hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                frames.write_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                frames.take_payload_item(s_tdata[7:0], s_tuser, s_tdata[15:8]);
            if (m_tvalid && m_tready)
                frames.check_frame_byte(m_tdata, m_tlast);
        end
    end

    task automatic send_item(input logic [7:0] data_byte, input logic [7:0] frame_type,
                             input logic [7:0] payload_length);
        if (!calm && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {payload_length, data_byte};
        s_tuser  <= frame_type;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic drive_frame(input logic [7:0] frame_type, input logic [7:0] payload_length,
                               input bit random_data, input bit noisy_tags);
        int count;
        logic [7:0] data_byte;
        count = (payload_length == 0) ? 1 : payload_length;
        for (int i = 0; i < count; i++) begin
            data_byte = random_data ? 8'($urandom_range(0, 255)) : 8'((i % 2) ? 8'hFF : 8'h00);
            if (i > 0 && noisy_tags)
                send_item(data_byte, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
                send_item(data_byte, frame_type, payload_length);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames.expected_frame_bytes.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [efe_pkg::CFG_IDX_W-1:0] index,
                             input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic enable, input logic [31:0] k0, input logic [31:0] k1,
                              input logic [31:0] k2, input logic [31:0] k3);
        write_reg(efe_pkg::CFG_ENCRYPT, {31'b0, enable});
        write_reg(efe_pkg::CFG_KEY0, k0);
        write_reg(efe_pkg::CFG_KEY1, k1);
        write_reg(efe_pkg::CFG_KEY2, k2);
        write_reg(efe_pkg::CFG_KEY3, k3);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_frames(input int budget);
        int start;
        int r;
        logic [7:0] frame_type;
        logic [7:0] payload_length;
        start = sent_items;
        while (sent_items - start < budget) begin
            r = $urandom_range(0, 99);
            frame_type = (r < 40) ? efe_pkg::FT_CYCLIC : (r < 70) ? efe_pkg::FT_WARN :
                         8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 4)       payload_length = 8'($urandom_range(97, 130));
            else if (r < 12) payload_length = 8'($urandom_range(88, 96));
            else if (r < 16) payload_length = 8'd0;
            else             payload_length = 8'($urandom_range(1, 20));
            drive_frame(frame_type, payload_length, 1'b1, $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        frames      = new();
        sent_items  = 0;
        calm        = 1'b0;
        hold_toggle = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = efe_pkg::CFG_ENCRYPT;
        cfg_data    = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames under reset register values
        drive_frame(efe_pkg::FT_CYCLIC, 8'd0, 1'b1, 1'b0);
        drive_frame(8'h07, 8'd0, 1'b1, 1'b0);
        drive_frame(efe_pkg::FT_CYCLIC, 8'd1, 1'b1, 1'b0);
        drive_frame(8'h00, 8'd2, 1'b0, 1'b0);
        drive_frame(efe_pkg::FT_WARN, 8'd8, 1'b0, 1'b0);
        drive_frame(8'hFF, 8'd3, 1'b1, 1'b1);
        drive_frame(efe_pkg::FT_WARN, 8'd9, 1'b1, 1'b0);
        wait_idle();

        set_config(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
        calm <= 1'b1;
        random_frames(18);
        wait_idle();
        calm <= 1'b0;

        set_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        hold_toggle <= ~hold_toggle;
        random_frames(18);
        wait_idle();

        set_config(1'b0, $urandom, $urandom, $urandom, $urandom);
        random_frames(18);
        wait_idle();

        set_config(1'b1, $urandom, $urandom, $urandom, $urandom);
        drive_frame(efe_pkg::FT_CYCLIC, 8'd255, 1'b1, 1'b0);
        random_frames(18);
        wait_idle();

        set_config(1'b1, efe_pkg::KEY0_RESET, efe_pkg::KEY1_RESET, efe_pkg::KEY2_RESET,
                   efe_pkg::KEY3_RESET);
        random_frames(18);
        wait_idle();

        $display("run covered %0d input items, %0d frames, %0d cipher blocks",
                 frames.items_taken, frames.frames_closed, frames.blocks_sealed);
        $display("%0d output items checked across six register settings",
                 frames.bytes_checked);
        if (frames.errors == 0 && frames.expected_frame_bytes.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
